>>> rtl/core/stbl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table lookup package
// Opcodes, fixed field widths and the control record shared by the chain.
// ----------------------------------------------------------------------------
package stbl_pkg;

   // Request opcodes carried in the request tuser.
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_AFTER  = 2'd2;
   localparam logic [1:0] OP_BEFORE = 2'd3;

   localparam int OP_BITS        = 2;
   localparam int VALUE_FLD_BITS = 32;
   localparam int INDEX_BITS     = 11;
   localparam int RSP_DATA_BITS  = 16;

   // Control record that travels with a query from cell to cell.
   typedef struct packed {
      logic valid;   // a query occupies this slot
      logic after;   // first-at-or-after query, else last-at-or-before
      logic done;    // answer already settled, no more bisection
      logic found;   // answer flag when done is set
   } ctl_type;

endpackage

>>> rtl/core/stbl_cell.sv
// ----------------------------------------------------------------------------
// Bisection cell
// One bisection step with its own copy of the table: reads the midpoint
// entry, then narrows the bracket and hands it to the next cell.
// ----------------------------------------------------------------------------
module stbl_cell #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_BITS  = 32,
   parameter int CW          = $clog2(TABLE_DEPTH + 1),
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  stbl_pkg::ctl_type     in_ctl,
   input  logic [CW-1:0]         in_lo,
   input  logic [CW-1:0]         in_hi,
   input  logic [VALUE_BITS-1:0] in_key,
   output stbl_pkg::ctl_type     out_ctl,
   output logic [CW-1:0]         out_lo,
   output logic [CW-1:0]         out_hi,
   output logic [VALUE_BITS-1:0] out_key
);

   logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];

   stbl_pkg::ctl_type     ctl_ff;
   logic [CW-1:0]         lo_ff;
   logic [CW-1:0]         hi_ff;
   logic [CW-1:0]         mid_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] rd_ff;

   logic [CW:0]   sum_in;
   logic [CW-1:0] mid_in;
   logic [CW-1:0] mid_m1;
   logic          step;
   logic          go_hi;

   assign sum_in = {1'b0, in_lo} + {1'b0, in_hi};
   assign mid_in = sum_in[CW:1];
   assign mid_m1 = mid_in - CW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_ff <= mem[mid_m1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff  <= in_lo;
         hi_ff  <= in_hi;
         mid_ff <= mid_in;
         key_ff <= in_key;
      end
   end

   // Bisect only while the bracket is wider than one position.
   assign step = ctl_ff.valid && !ctl_ff.done && ({1'b0, hi_ff} > ({1'b0, lo_ff} + 1'b1));

   // The after query moves hi down on entry >= key; the before query moves
   // lo up on entry <= key and hi down otherwise.
   assign go_hi = ctl_ff.after ? (rd_ff >= key_ff) : !(rd_ff <= key_ff);

   always_comb begin
      out_lo = lo_ff;
      out_hi = hi_ff;
      if (step) begin
         if (go_hi) begin
            out_hi = mid_ff;
         end else begin
            out_lo = mid_ff;
         end
      end
   end

   assign out_ctl = ctl_ff;
   assign out_key = key_ff;

endmodule

>>> rtl/core/sorted_table_bisection_lookup_core.sv
// ----------------------------------------------------------------------------
// Sorted table bisection lookup core
// Keeps an appended table of signed values and answers lower and upper
// bound queries by bisection through a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_*) carries one command per beat: the opcode in
// req_tuser and a signed value in req_tdata. Clear and append beats return
// nothing; the two query opcodes each return one beat on the response
// channel (rsp_*) with the found flag in rsp_tuser and the 1-based index in
// rsp_tdata.
// A query is captured by the first of clog2(TABLE_DEPTH) bisection cells
// at its accepting edge, moves one cell per cycle while the chain is not
// held and lands in the response register from the last cell, so the
// length of the cell chain sets how long a query takes to answer. Only one
// query is in the chain at a time; req_tready is low while it is there, so
// the next beat is taken once the response is loaded.
// Reset empties the table (entry count zero) and drops any query in flight.
// The table storage itself is not cleared; only entries written since the
// last clear are ever read.
// While a response waits with rsp_tready low, new clear and append beats are
// still taken, and a following query advances up to the last cell and holds
// there until the response register frees.
// ----------------------------------------------------------------------------
module sorted_table_bisection_lookup_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [stbl_pkg::VALUE_FLD_BITS-1:0] req_tdata,  // [31:0] value
   input  logic [stbl_pkg::OP_BITS-1:0]        req_tuser,  // [1:0] op
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [stbl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // [10:0] index, [15:11] zero
   output logic [0:0]  rsp_tuser     // [0] found
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NC = $clog2(TABLE_DEPTH);
   localparam int PAD = stbl_pkg::RSP_DATA_BITS - stbl_pkg::INDEX_BITS;
   localparam logic [VALUE_BITS-1:0] KEY_FLIP = {1'b1, {(VALUE_BITS - 1){1'b0}}};

   // Table bookkeeping: count plus copies of the first and last entries,
   // which settle the bound checks before any bisection.
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [VALUE_BITS-1:0] first_ff;
   logic [VALUE_BITS-1:0] last_ff;

   logic                  req_acc;
   logic                  app_en;
   logic                  busy;
   logic                  adv;
   logic [VALUE_BITS-1:0] key;

   stbl_pkg::ctl_type     launch_ctl;
   logic [CW-1:0]         launch_lo;
   logic [CW-1:0]         launch_hi;

   stbl_pkg::ctl_type     chain_ctl [NC + 1];
   logic [CW-1:0]         chain_lo  [NC + 1];
   logic [CW-1:0]         chain_hi  [NC + 1];
   logic [VALUE_BITS-1:0] chain_key [NC + 1];
   logic [NC-1:0]         vld_vec;

   logic                            rsp_valid_ff;
   logic                            rsp_found_ff;
   logic [stbl_pkg::INDEX_BITS-1:0] rsp_index_ff;
   logic                            fin_found;
   logic [CW-1:0]                   fin_idx;

   // Values are compared as unsigned keys with the sign bit flipped.
   assign key = VALUE_BITS'(req_tdata) ^ KEY_FLIP;

   assign busy       = |vld_vec;
   assign req_tready = !busy;
   assign req_acc    = req_tvalid && req_tready;
   assign app_en     = req_acc && (req_tuser == stbl_pkg::OP_APPEND)
                       && (count_ff < CW'(TABLE_DEPTH));

   // The chain holds while a finished query cannot leave the last cell.
   assign adv = !(chain_ctl[NC].valid && rsp_valid_ff && !rsp_tready);

   always_comb begin
      count_in = count_ff;
      if (req_acc && (req_tuser == stbl_pkg::OP_CLEAR)) begin
         count_in = '0;
      end else if (app_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (app_en) begin
         last_ff <= key;
         if (count_ff == '0) begin
            first_ff <= key;
         end
      end
   end

   // Launch: bound checks on the incoming query. A settled answer rides the
   // chain with lo and hi both holding its index.
   always_comb begin
      launch_ctl       = '0;
      launch_ctl.valid = req_acc
                         && (req_tuser inside {stbl_pkg::OP_AFTER, stbl_pkg::OP_BEFORE});
      launch_ctl.after = (req_tuser == stbl_pkg::OP_AFTER);
      launch_lo        = CW'(1);
      launch_hi        = count_ff;
      if (count_ff == '0) begin
         launch_ctl.done = 1'b1;
         launch_lo       = '0;
         launch_hi       = '0;
      end else if (launch_ctl.after) begin
         if (key > last_ff) begin
            launch_ctl.done = 1'b1;
            launch_lo       = '0;
            launch_hi       = '0;
         end else if (first_ff >= key) begin
            launch_ctl.done  = 1'b1;
            launch_ctl.found = 1'b1;
            launch_hi        = CW'(1);
         end
      end else begin
         if (key >= last_ff) begin
            launch_ctl.done  = 1'b1;
            launch_ctl.found = 1'b1;
            launch_lo        = count_ff;
         end else if (key < first_ff) begin
            launch_ctl.done = 1'b1;
            launch_lo       = '0;
            launch_hi       = '0;
         end
      end
   end

   assign chain_ctl[0] = launch_ctl;
   assign chain_lo[0]  = launch_lo;
   assign chain_hi[0]  = launch_hi;
   assign chain_key[0] = key;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      stbl_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .VALUE_BITS  (VALUE_BITS),
         .CW          (CW),
         .AW          (AW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .wr_en   (app_en),
         .wr_addr (count_ff[AW-1:0]),
         .wr_data (key),
         .in_ctl  (chain_ctl[i]),
         .in_lo   (chain_lo[i]),
         .in_hi   (chain_hi[i]),
         .in_key  (chain_key[i]),
         .out_ctl (chain_ctl[i + 1]),
         .out_lo  (chain_lo[i + 1]),
         .out_hi  (chain_hi[i + 1]),
         .out_key (chain_key[i + 1])
      );
      assign vld_vec[i] = chain_ctl[i + 1].valid;
   end

   // A bisected after query answers hi, a before query answers lo.
   assign fin_found = chain_ctl[NC].done ? chain_ctl[NC].found : 1'b1;
   assign fin_idx   = chain_ctl[NC].after ? chain_hi[NC] : chain_lo[NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ctl[NC].valid && adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ctl[NC].valid && adv) begin
         rsp_found_ff <= fin_found;
         rsp_index_ff <= stbl_pkg::INDEX_BITS'(fin_idx);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, rsp_index_ff};
   assign rsp_tuser  = rsp_found_ff;

   // Only one query may be in the chain at any time.
   a_one_query: assert property (@(posedge clock) disable iff (reset)
      $countones(vld_vec) <= 1)
      else $error("more than one query in the cell chain");

   // The entry count never passes the table depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The chain is long enough to close every bracket.
   a_bracket_closed: assert property (@(posedge clock) disable iff (reset)
      (chain_ctl[NC].valid && !chain_ctl[NC].done) |->
         ({1'b0, chain_hi[NC]} <= ({1'b0, chain_lo[NC]} + 1'b1)))
      else $error("bisection not finished at end of chain");

   // A found answer points inside the filled part of the table.
   a_index_inside: assert property (@(posedge clock) disable iff (reset)
      (chain_ctl[NC].valid && fin_found) |->
         (fin_idx != '0) && (fin_idx <= count_ff))
      else $error("found index outside the table");

endmodule
